>>> rtl/core/htbl_pkg.sv
// ----------------------------------------------------------------------------
// htbl_pkg: hash tree block locator shared types and constants
// Tree geometry, field widths and the per-row table record.
// ----------------------------------------------------------------------------
`default_nettype none

package htbl_pkg;

   // tree geometry; both block sizes must be powers of two
   localparam int HB_HASHES  = 512;    // hashes in one hash block
   localparam int FB_BYTES   = 8192;   // bytes in one file block
   localparam int HASH_BYTES = 20;
   localparam int MAX_ROWS   = 8;

   localparam int HBS_LOG = $clog2(HB_HASHES);
   localparam int FBS_LOG = $clog2(FB_BYTES);

   // port widths
   localparam int FS_W   = 48;
   localparam int BLK_W  = 32;
   localparam int BOFF_W = 40;
   localparam int BSZ_W  = 14;
   localparam int FC_W   = 36;

   // internal widths
   localparam int LEN_W  = FS_W + 1 - FBS_LOG;          // hashes in one row
   localparam int OFF_W  = LEN_W + 1;                    // hashes above a row
   localparam int SIZE_W = $clog2(HB_HASHES + 1);        // hashes in one block
   localparam int ROW_W  = $clog2(MAX_ROWS);
   localparam int CNT_W  = $clog2(MAX_ROWS + 1);

   typedef struct packed {
      logic [LEN_W-1:0] len;       // hashes in row
      logic [OFF_W-1:0] off;       // hashes in all rows above
      logic [OFF_W-1:0] prev_off;  // start of the row above
      logic [BLK_W-1:0] bb;        // first block number of row
      logic [BLK_W-1:0] bb_next;   // first block number of next row
   } row_info_type;

   typedef struct packed {
      logic             busy;
      logic [CNT_W-1:0] row_count;
   } build_status_type;

endpackage

`default_nettype wire

>>> rtl/core/htbl_rows.sv
// ----------------------------------------------------------------------------
// htbl_rows: row table builder
// Rebuilds the per-row lengths, offsets and block numbers after a file size
// write: one row per cycle bottom-up, then one row per cycle root-first.
// ----------------------------------------------------------------------------
`default_nettype none

module htbl_rows (
   input  wire                                    clock,
   input  wire                                    reset,
   input  wire                                    csr_valid,
   output logic                                   csr_ready,
   input  wire  [htbl_pkg::FS_W-1:0]              csr_file_size,
   output htbl_pkg::row_info_type [htbl_pkg::MAX_ROWS-1:0] rows,
   output htbl_pkg::build_status_type             status
);

   typedef enum logic [1:0] {B_IDLE, B_UP, B_DOWN} build_state_type;

   build_state_type                       state_ff;
   logic [htbl_pkg::LEN_W-1:0]            up_len_ff [htbl_pkg::MAX_ROWS];
   logic [htbl_pkg::CNT_W-1:0]            cnt_ff;
   logic [htbl_pkg::CNT_W-1:0]            n_ff;
   logic [htbl_pkg::LEN_W-1:0]            cur_ff;
   logic [htbl_pkg::ROW_W-1:0]            x_ff;
   logic [htbl_pkg::OFF_W-1:0]            off_ff;
   logic [htbl_pkg::OFF_W-1:0]            prev_ff;
   logic [htbl_pkg::BLK_W-1:0]            bb_ff;
   htbl_pkg::row_info_type [htbl_pkg::MAX_ROWS-1:0] rows_ff;

   logic [htbl_pkg::FS_W:0]               fs_sum;
   logic [htbl_pkg::LEN_W-1:0]            leaves;
   logic [htbl_pkg::LEN_W:0]              cur_sum;
   logic [htbl_pkg::LEN_W-1:0]            cur_up;
   logic [htbl_pkg::ROW_W-1:0]            rd_idx;
   logic [htbl_pkg::LEN_W-1:0]            dn_len;
   logic [htbl_pkg::LEN_W:0]              dn_sum;
   logic [htbl_pkg::BLK_W-1:0]            dn_rb;

   always_comb begin
      fs_sum  = {1'b0, csr_file_size} + (htbl_pkg::FS_W+1)'(htbl_pkg::FB_BYTES - 1);
      leaves  = htbl_pkg::LEN_W'(fs_sum >> htbl_pkg::FBS_LOG);
      cur_sum = {1'b0, cur_ff} + (htbl_pkg::LEN_W+1)'(htbl_pkg::HB_HASHES - 1);
      cur_up  = htbl_pkg::LEN_W'(cur_sum >> htbl_pkg::HBS_LOG);
      // rows are held bottom-up while counting; read them back root first
      rd_idx  = htbl_pkg::ROW_W'(cnt_ff - htbl_pkg::CNT_W'(1) - htbl_pkg::CNT_W'(x_ff));
      dn_len  = up_len_ff[rd_idx];
      dn_sum  = {1'b0, dn_len} + (htbl_pkg::LEN_W+1)'(htbl_pkg::HB_HASHES - 1);
      dn_rb   = htbl_pkg::BLK_W'(dn_sum >> htbl_pkg::HBS_LOG);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= B_IDLE;
         n_ff     <= '0;
      end else begin
         case (state_ff)
            B_IDLE: begin
               if (csr_valid) begin
                  n_ff <= '0;
                  if (leaves != '0) begin
                     up_len_ff[0] <= leaves;
                     cur_ff       <= leaves;
                     cnt_ff       <= htbl_pkg::CNT_W'(1);
                     state_ff     <= B_UP;
                  end
               end
            end
            B_UP: begin
               if (cur_ff > htbl_pkg::LEN_W'(1)) begin
                  if (cnt_ff == htbl_pkg::CNT_W'(htbl_pkg::MAX_ROWS)) begin
                     // too many rows: keep none
                     state_ff <= B_IDLE;
                  end else begin
                     up_len_ff[cnt_ff[htbl_pkg::ROW_W-1:0]] <= cur_up;
                     cur_ff <= cur_up;
                     cnt_ff <= cnt_ff + htbl_pkg::CNT_W'(1);
                  end
               end else begin
                  x_ff     <= '0;
                  off_ff   <= '0;
                  prev_ff  <= '0;
                  bb_ff    <= '0;
                  state_ff <= B_DOWN;
               end
            end
            B_DOWN: begin
               rows_ff[x_ff].len      <= dn_len;
               rows_ff[x_ff].off      <= off_ff;
               rows_ff[x_ff].prev_off <= prev_ff;
               rows_ff[x_ff].bb       <= bb_ff;
               rows_ff[x_ff].bb_next  <= bb_ff + dn_rb;
               off_ff  <= off_ff + htbl_pkg::OFF_W'(dn_len);
               prev_ff <= off_ff;
               bb_ff   <= bb_ff + dn_rb;
               x_ff    <= x_ff + htbl_pkg::ROW_W'(1);
               if (htbl_pkg::CNT_W'(x_ff) + htbl_pkg::CNT_W'(1) == cnt_ff) begin
                  n_ff     <= cnt_ff;
                  state_ff <= B_IDLE;
               end
            end
            default: state_ff <= B_IDLE;
         endcase
      end
   end

   assign csr_ready        = (state_ff == B_IDLE);
   assign rows             = rows_ff;
   assign status.busy      = (state_ff != B_IDLE);
   assign status.row_count = n_ff;

endmodule

`default_nettype wire

>>> rtl/core/htbl_pipe.sv
// ----------------------------------------------------------------------------
// htbl_pipe: block lookup pipeline
// One register stage per row to find the block's row, then two arithmetic
// stages. All stages move together on advance.
// ----------------------------------------------------------------------------
`default_nettype none

module htbl_pipe (
   input  wire                                     clock,
   input  wire                                     reset,
   input  wire                                     advance,
   input  wire                                     in_vld,
   input  wire  [htbl_pkg::BLK_W-1:0]              in_blk,
   input  htbl_pkg::row_info_type [htbl_pkg::MAX_ROWS-1:0] rows,
   input  wire  [htbl_pkg::CNT_W-1:0]              row_count,
   output logic                                    out_vld,
   output logic                                    valid_res,
   output logic [htbl_pkg::BOFF_W-1:0]             byte_offset,
   output logic [htbl_pkg::BSZ_W-1:0]              byte_size,
   output logic [htbl_pkg::BOFF_W-1:0]             parent_offset,
   output logic                                    has_tree_children,
   output logic [htbl_pkg::BLK_W-1:0]              tree_child_first,
   output logic [htbl_pkg::BLK_W-1:0]              tree_child_end,
   output logic                                    is_leaf_row,
   output logic [htbl_pkg::FC_W-1:0]               file_child_first,
   output logic [htbl_pkg::FC_W-1:0]               file_child_end
);

   typedef struct packed {
      logic [htbl_pkg::BLK_W-1:0] blk;
      logic                       found;
      logic                       root;
      logic                       leaf;
      logic [htbl_pkg::BLK_W-1:0] idx;
      logic [htbl_pkg::LEN_W-1:0] len;
      logic [htbl_pkg::OFF_W-1:0] off;
      logic [htbl_pkg::OFF_W-1:0] prev_off;
      logic [htbl_pkg::BLK_W-1:0] bb_next;
   } scan_type;

   typedef struct packed {
      logic                        found;
      logic                        root;
      logic                        leaf;
      logic [htbl_pkg::LEN_W-1:0]  in_row;   // first hash index within row
      logic [htbl_pkg::OFF_W-1:0]  first;
      logic [htbl_pkg::SIZE_W-1:0] size;
      logic [htbl_pkg::BLK_W-1:0]  child;
      logic [htbl_pkg::OFF_W-1:0]  pbase;
   } arith_type;

   logic     [htbl_pkg::MAX_ROWS:0] vld_ff;
   scan_type [htbl_pkg::MAX_ROWS:0] scan_ff;
   scan_type [htbl_pkg::MAX_ROWS:0] scan_in;
   logic                            ar_vld_ff;
   arith_type                       ar_ff;
   arith_type                       ar_in;
   logic                            o_vld_ff;

   logic [htbl_pkg::LEN_W-1:0]      a_rem;
   scan_type                        last;

   logic                            valid_res_in;
   logic [htbl_pkg::BOFF_W-1:0]     byte_offset_in;
   logic [htbl_pkg::BSZ_W-1:0]      byte_size_in;
   logic [htbl_pkg::BOFF_W-1:0]     parent_offset_in;
   logic                            has_tree_children_in;
   logic [htbl_pkg::BLK_W-1:0]      tree_child_first_in;
   logic [htbl_pkg::BLK_W-1:0]      tree_child_end_in;
   logic                            is_leaf_row_in;
   logic [htbl_pkg::FC_W-1:0]       file_child_first_in;
   logic [htbl_pkg::FC_W-1:0]       file_child_end_in;

   // row search: stage k+1 is stage k checked against row k
   always_comb begin
      scan_in[0]       = '0;
      scan_in[0].blk   = in_blk;
      for (int k = 0; k < htbl_pkg::MAX_ROWS; k++) begin
         scan_in[k+1] = scan_ff[k];
         if (!scan_ff[k].found
             && (htbl_pkg::CNT_W'(k) < row_count)
             && (scan_ff[k].blk >= rows[k].bb)
             && (scan_ff[k].blk < rows[k].bb_next)) begin
            scan_in[k+1].found    = 1'b1;
            scan_in[k+1].root     = (k == 0);
            scan_in[k+1].leaf     = (htbl_pkg::CNT_W'(k + 1) == row_count);
            scan_in[k+1].idx      = scan_ff[k].blk - rows[k].bb;
            scan_in[k+1].len      = rows[k].len;
            scan_in[k+1].off      = rows[k].off;
            scan_in[k+1].prev_off = rows[k].prev_off;
            scan_in[k+1].bb_next  = rows[k].bb_next;
         end
      end
   end

   always_comb begin
      last         = scan_ff[htbl_pkg::MAX_ROWS];
      ar_in.found  = last.found;
      ar_in.root   = last.root;
      ar_in.leaf   = last.leaf;
      ar_in.in_row = htbl_pkg::LEN_W'(last.idx) << htbl_pkg::HBS_LOG;
      ar_in.first  = last.off + htbl_pkg::OFF_W'(ar_in.in_row);
      a_rem        = last.len - ar_in.in_row;
      if (a_rem > htbl_pkg::LEN_W'(htbl_pkg::HB_HASHES)) begin
         ar_in.size = htbl_pkg::SIZE_W'(htbl_pkg::HB_HASHES);
      end else begin
         ar_in.size = a_rem[htbl_pkg::SIZE_W-1:0];
      end
      ar_in.child  = htbl_pkg::BLK_W'(ar_in.in_row) + last.bb_next;
      ar_in.pbase  = last.prev_off + htbl_pkg::OFF_W'(last.idx);
   end

   always_comb begin
      valid_res_in         = ar_ff.found;
      byte_offset_in       = '0;
      byte_size_in         = '0;
      parent_offset_in     = '0;
      has_tree_children_in = 1'b0;
      tree_child_first_in  = '0;
      tree_child_end_in    = '0;
      is_leaf_row_in       = 1'b0;
      file_child_first_in  = '0;
      file_child_end_in    = '0;
      if (ar_ff.found) begin
         byte_offset_in = htbl_pkg::BOFF_W'(ar_ff.first)
                          * htbl_pkg::BOFF_W'(htbl_pkg::HASH_BYTES);
         byte_size_in   = htbl_pkg::BSZ_W'(ar_ff.size)
                          * htbl_pkg::BSZ_W'(htbl_pkg::HASH_BYTES);
         if (!ar_ff.root) begin
            parent_offset_in = htbl_pkg::BOFF_W'(ar_ff.pbase)
                               * htbl_pkg::BOFF_W'(htbl_pkg::HASH_BYTES);
         end
         if (ar_ff.leaf) begin
            is_leaf_row_in      = 1'b1;
            file_child_first_in = htbl_pkg::FC_W'(ar_ff.in_row);
            file_child_end_in   = htbl_pkg::FC_W'(ar_ff.in_row)
                                  + htbl_pkg::FC_W'(ar_ff.size);
         end else begin
            has_tree_children_in = 1'b1;
            tree_child_first_in  = ar_ff.child;
            tree_child_end_in    = ar_ff.child + htbl_pkg::BLK_W'(ar_ff.size);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff    <= '0;
         ar_vld_ff <= 1'b0;
         o_vld_ff  <= 1'b0;
      end else if (advance) begin
         vld_ff    <= {vld_ff[htbl_pkg::MAX_ROWS-1:0], in_vld};
         ar_vld_ff <= vld_ff[htbl_pkg::MAX_ROWS];
         o_vld_ff  <= ar_vld_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         scan_ff           <= scan_in;
         ar_ff             <= ar_in;
         valid_res         <= valid_res_in;
         byte_offset       <= byte_offset_in;
         byte_size         <= byte_size_in;
         parent_offset     <= parent_offset_in;
         has_tree_children <= has_tree_children_in;
         tree_child_first  <= tree_child_first_in;
         tree_child_end    <= tree_child_end_in;
         is_leaf_row       <= is_leaf_row_in;
         file_child_first  <= file_child_first_in;
         file_child_end    <= file_child_end_in;
      end
   end

   assign out_vld = o_vld_ff;

endmodule

`default_nettype wire

>>> rtl/core/hash_tree_block_locator_top.sv
// ----------------------------------------------------------------------------
// hash_tree_block_locator_top: hash tree block locator
// Gives place, size, parent and children of a stored hash tree block.
// ----------------------------------------------------------------------------
//  channel | direction | handshake          | beat
//  req_    | in        | req_valid/req_stall| block number
//  rsp_    | out       | rsp_valid/rsp_stall| location fields of that block
//  csr_    | in        | csr_valid/csr_ready| file size
//
//  One block number a cycle while req_stall is low; rsp_valid rises once the
//  block has passed the input register, one stage per row, one arithmetic stage
//  and the output register.
//  A file size write rebuilds the row table; req_stall stays high meanwhile.
//  Reset clears the table to no rows: every block then reads invalid.
//  rsp_stall while rsp_valid is high holds the whole pipeline in place.
// ----------------------------------------------------------------------------
`default_nettype none

module hash_tree_block_locator_top (
   input  wire                          clock,
   input  wire                          reset,
   input  wire                          req_valid,
   output logic                         req_stall,
   input  wire  [htbl_pkg::BLK_W-1:0]   req_block_number,
   output logic                         rsp_valid,
   input  wire                          rsp_stall,
   output logic                         rsp_valid_res,
   output logic [htbl_pkg::BOFF_W-1:0]  rsp_byte_offset,
   output logic [htbl_pkg::BSZ_W-1:0]   rsp_byte_size,
   output logic [htbl_pkg::BOFF_W-1:0]  rsp_parent_offset,
   output logic                         rsp_has_tree_children,
   output logic [htbl_pkg::BLK_W-1:0]   rsp_tree_child_first,
   output logic [htbl_pkg::BLK_W-1:0]   rsp_tree_child_end,
   output logic                         rsp_is_leaf_row,
   output logic [htbl_pkg::FC_W-1:0]    rsp_file_child_first,
   output logic [htbl_pkg::FC_W-1:0]    rsp_file_child_end,
   input  wire                          csr_valid,
   output logic                         csr_ready,
   input  wire  [htbl_pkg::FS_W-1:0]    csr_file_size
);

   htbl_pkg::row_info_type [htbl_pkg::MAX_ROWS-1:0] rows;
   htbl_pkg::build_status_type                      status;
   logic                                            advance;
   logic                                            req_take;

   assign advance  = !(rsp_valid && rsp_stall);
   assign req_stall = status.busy || !advance;
   assign req_take  = req_valid && !req_stall;

   htbl_rows u_rows (
      .clock         (clock),
      .reset         (reset),
      .csr_valid     (csr_valid),
      .csr_ready     (csr_ready),
      .csr_file_size (csr_file_size),
      .rows          (rows),
      .status        (status)
   );

   htbl_pipe u_pipe (
      .clock             (clock),
      .reset             (reset),
      .advance           (advance),
      .in_vld            (req_take),
      .in_blk            (req_block_number),
      .rows              (rows),
      .row_count         (status.row_count),
      .out_vld           (rsp_valid),
      .valid_res         (rsp_valid_res),
      .byte_offset       (rsp_byte_offset),
      .byte_size         (rsp_byte_size),
      .parent_offset     (rsp_parent_offset),
      .has_tree_children (rsp_has_tree_children),
      .tree_child_first  (rsp_tree_child_first),
      .tree_child_end    (rsp_tree_child_end),
      .is_leaf_row       (rsp_is_leaf_row),
      .file_child_first  (rsp_file_child_first),
      .file_child_end    (rsp_file_child_end)
   );

   // a located block is either in the leaf row or has tree children
   a_leaf_xor_tree: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_valid_res |-> (rsp_is_leaf_row ^ rsp_has_tree_children))
      else $error("located block must be leaf or tree parent");

   // an invalid block carries no location
   a_invalid_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_valid_res |-> (rsp_byte_size == '0) && (rsp_byte_offset == '0)
         && !rsp_is_leaf_row && !rsp_has_tree_children)
      else $error("invalid block with non-zero fields");

   // no block number taken while the row table is rebuilt
   a_build_blocks_req: assert property (@(posedge clock) disable iff (reset)
      status.busy |-> req_stall)
      else $error("request taken during table rebuild");

endmodule

`default_nettype wire
